// ===== rtl/core/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// Used by fbpa_serial_unit and fixed_block_pool_allocator_unit; no dependencies.
package fbpa_pkg;

    localparam int DATA_W         = 32;
    localparam int SIZE_W         = 16;
    localparam int STATUS_W       = 3;
    localparam int COUNT_OUT_W    = 9;
    localparam int STEP_W         = 6;
    localparam int BLOCKS_DEFAULT = 256;

    localparam logic [DATA_W-1:0] BASE_RESET = 32'd4096;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_NULL  = 3'd2,
        ST_BAD   = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_BASE = 1'b0,
        REG_SIZE = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_START,
        S_ARITH,
        S_FINISH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctrl_t;

endpackage

// ===== rtl/core/fbpa_serial_unit.sv =====
// Bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Depends on fbpa_pkg for widths, the operation code and the control struct.
module fbpa_serial_unit
    import fbpa_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  arith_ctrl_t       ctrl,
    input  logic [DATA_W-1:0] operand,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] result,
    output logic [SIZE_W-1:0] remainder
);

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DATA_W - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(IDX_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] count_reg;
    arith_op_t         op_reg;

    logic [DATA_W-1:0] shift_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] mcand_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] div_reg;

    logic [SIZE_W+1:0] trial;
    logic              qbit;

    // one quotient bit per cycle: shift the next dividend bit into the remainder
    assign trial = {1'b0, rem_reg, shift_reg[DATA_W-1]} - {2'b00, div_reg};
    assign qbit  = ~trial[SIZE_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            op_reg    <= OP_MUL;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == '0);
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                op_reg    <= ctrl.op;
                count_reg <= (ctrl.op == OP_DIV) ? DIV_LAST : MUL_LAST;
            end
            else if (busy_reg)
            begin
                if (count_reg == '0)
                    busy_reg <= 1'b0;
                else
                    count_reg <= count_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            shift_reg <= operand;
            acc_reg   <= '0;
            rem_reg   <= '0;
            div_reg   <= divisor;
            mcand_reg <= DATA_W'(divisor);
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                rem_reg   <= qbit ? trial[SIZE_W-1:0]
                                  : {rem_reg[SIZE_W-2:0], shift_reg[DATA_W-1]};
                shift_reg <= {shift_reg[DATA_W-2:0], qbit};
            end
            else
            begin
                // add the shifted multiplicand when the low multiplier bit is set
                if (shift_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[DATA_W-2:0], 1'b0};
                shift_reg <= {1'b0, shift_reg[DATA_W-1:1]};
            end
        end
    end

    assign done      = done_reg;
    assign result    = (op_reg == OP_DIV) ? shift_reg : acc_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/fixed_block_pool_allocator_unit.sv =====
// Fixed block pool allocator: LIFO free stack of block indices, usage counters.
// Depends on fbpa_pkg and fbpa_serial_unit.
// Allocate multiplies the popped index by the block size on the shift-add multiplier;
// free divides the address offset by the block size, one quotient bit a cycle; a null
// free or an empty pool skips the arithmetic. One item at a time; the result register frees
// the input for the next item. Async active-low reset restores state, settings and counters;
// the stack needs no clearing pass, a fill mark makes unwritten entries read as their index.
module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int BLOCKS = BLOCKS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [DATA_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   req_type,
    input  logic [DATA_W-1:0]      free_address,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [DATA_W-1:0]      block_address,
    output logic [COUNT_OUT_W-1:0] live_blocks,
    output logic [COUNT_OUT_W-1:0] peak_blocks,
    output logic [DATA_W-1:0]      total_allocated,
    output logic [DATA_W-1:0]      total_freed
);

    localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W = $clog2(BLOCKS + 1);

    localparam logic [CNT_W-1:0]  CNT_BLOCKS  = CNT_W'(BLOCKS);
    localparam logic [DATA_W-1:0] DATA_BLOCKS = DATA_W'(BLOCKS);

    state_t state_reg, state_next;

    logic [DATA_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [DATA_W-1:0] alloc_reg, alloc_next;
    logic [DATA_W-1:0] freed_reg, freed_next;
    logic              out_valid_reg, out_valid_next;

    logic              kind_reg, kind_next;
    logic [DATA_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic              fresh_reg, fresh_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] addr_out_reg, addr_out_next;

    status_t           status_out_reg;
    logic [DATA_W-1:0] block_out_reg;
    logic [CNT_W-1:0]  live_out_reg;
    logic [CNT_W-1:0]  peak_out_reg;
    logic [DATA_W-1:0] alloc_out_reg;
    logic [DATA_W-1:0] freed_out_reg;

    logic [IDX_W-1:0]  stack_mem [BLOCKS];
    logic [IDX_W-1:0]  rd_data_reg;

    logic              push;
    logic              load_out;
    logic [CNT_W-1:0]  depth_dec;
    logic [CNT_W-1:0]  live_inc;
    logic [IDX_W-1:0]  pop_index;
    logic [DATA_W:0]   offset;
    logic              bad_addr;

    arith_ctrl_t       arith_ctrl;
    logic [DATA_W-1:0] arith_operand;
    logic              arith_done;
    logic [DATA_W-1:0] arith_result;
    logic [SIZE_W-1:0] arith_rem;

    logic [CNT_W+COUNT_OUT_W-1:0] live_ext;
    logic [CNT_W+COUNT_OUT_W-1:0] peak_ext;

    fbpa_serial_unit #(
        .IDX_W(IDX_W)
    ) u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (arith_ctrl),
        .operand  (arith_operand),
        .divisor  (size_reg),
        .done     (arith_done),
        .result   (arith_result),
        .remainder(arith_rem)
    );

    assign depth_dec = depth_reg - CNT_W'(1);
    assign live_inc  = live_reg + CNT_W'(1);
    // entries below the fill mark were never written and still hold their own index
    assign pop_index = fresh_reg ? pos_reg : rd_data_reg;
    assign offset    = {1'b0, addr_reg} - {1'b0, base_reg};
    assign bad_addr  = (size_reg == '0) || offset[DATA_W] || (arith_rem != '0)
                       || (arith_result >= DATA_BLOCKS);

    assign arith_operand = kind_reg ? offset[DATA_W-1:0]
                                    : {{(DATA_W-IDX_W){1'b0}}, pop_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BASE: base_reg <= cfg_data;
                REG_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= CNT_BLOCKS;
            fill_reg      <= CNT_BLOCKS;
            live_reg      <= '0;
            peak_reg      <= '0;
            alloc_reg     <= '0;
            freed_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            fill_reg      <= fill_next;
            live_reg      <= live_next;
            peak_reg      <= peak_next;
            alloc_reg     <= alloc_next;
            freed_reg     <= freed_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        pos_reg      <= pos_next;
        fresh_reg    <= fresh_next;
        addr_out_reg <= addr_out_next;
        if (load_out)
        begin
            status_out_reg <= status_reg;
            block_out_reg  <= addr_out_reg;
            live_out_reg   <= live_reg;
            peak_out_reg   <= peak_reg;
            alloc_out_reg  <= alloc_reg;
            freed_out_reg  <= freed_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[depth_reg[IDX_W-1:0]] <= arith_result[IDX_W-1:0];
        rd_data_reg <= stack_mem[pos_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        fill_next      = fill_reg;
        live_next      = live_reg;
        peak_next      = peak_reg;
        alloc_next     = alloc_reg;
        freed_next     = freed_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        fresh_next     = fresh_reg;
        status_next    = status_reg;
        addr_out_next  = addr_out_reg;
        arith_ctrl     = '{start: 1'b0, op: OP_MUL};
        push           = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = req_type;
                    addr_next     = free_address;
                    addr_out_next = '0;
                    if (!req_type)
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            // pop: the top entry sits just below the current depth
                            depth_next = depth_dec;
                            pos_next   = depth_dec[IDX_W-1:0];
                            fresh_next = (depth_dec < fill_reg);
                            if (depth_dec < fill_reg)
                                fill_next = depth_dec;
                            state_next = S_READ;
                        end
                    end
                    else if (free_address == '0)
                    begin
                        status_next = ST_NULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_START;
            end

            S_START:
            begin
                arith_ctrl = '{start: 1'b1, op: (kind_reg ? OP_DIV : OP_MUL)};
                state_next = S_ARITH;
            end

            S_ARITH:
            begin
                if (arith_done)
                    state_next = S_FINISH;
            end

            S_FINISH:
            begin
                state_next = S_DONE;
                if (!kind_reg)
                begin
                    status_next   = ST_OK;
                    addr_out_next = base_reg + arith_result;
                    alloc_next    = alloc_reg + DATA_W'(1);
                    live_next     = live_inc;
                    if (live_inc > peak_reg)
                        peak_next = live_inc;
                end
                else if (bad_addr)
                begin
                    status_next = ST_BAD;
                end
                else if (depth_reg >= CNT_BLOCKS)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    push        = 1'b1;
                    depth_next  = depth_reg + CNT_W'(1);
                    freed_next  = freed_reg + DATA_W'(1);
                    if (live_reg != '0)
                        live_next = live_reg - CNT_W'(1);
                end
            end

            S_DONE:
            begin
                // hold until the result register is free or draining this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall = (state_reg != S_IDLE);

    assign live_ext = {{COUNT_OUT_W{1'b0}}, live_out_reg};
    assign peak_ext = {{COUNT_OUT_W{1'b0}}, peak_out_reg};

    assign out_valid       = out_valid_reg;
    assign status          = status_out_reg;
    assign block_address   = block_out_reg;
    assign live_blocks     = live_ext[COUNT_OUT_W-1:0];
    assign peak_blocks     = peak_ext[COUNT_OUT_W-1:0];
    assign total_allocated = alloc_out_reg;
    assign total_freed     = freed_out_reg;

endmodule

// ===== tb/sv/fixed_block_pool_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_pool_allocator_unit: allocate and free traffic
// against a behavioral pool model, each result compared field by field in arrival order.
// Depends on fbpa_pkg and the allocator RTL.
module fixed_block_pool_allocator_unit_tb;
    import fbpa_pkg::*;

    localparam int NBLK   = BLOCKS_DEFAULT;
    localparam int IDX_W  = $clog2(NBLK);
    localparam int LIMIT  = 1000000;
    localparam int SETTLE = 48;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        status_t                status;
        logic [DATA_W-1:0]      addr;
        logic [COUNT_OUT_W-1:0] live;
        logic [COUNT_OUT_W-1:0] peak;
        logic [DATA_W-1:0]      allocs;
        logic [DATA_W-1:0]      frees;
    } pool_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [0:0]             cfg_index = REG_BASE;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = REQ_ALLOC;
    logic [DATA_W-1:0]      free_address = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [DATA_W-1:0]      block_address;
    logic [COUNT_OUT_W-1:0] live_blocks;
    logic [COUNT_OUT_W-1:0] peak_blocks;
    logic [DATA_W-1:0]      total_allocated;
    logic [DATA_W-1:0]      total_freed;

    // pool model state
    logic [DATA_W-1:0] pool_base;
    logic [SIZE_W-1:0] pool_size;
    logic [IDX_W-1:0]  free_stack [NBLK];
    int unsigned       free_depth;
    int unsigned       live_count;
    int unsigned       peak_count;
    logic [DATA_W-1:0] alloc_count;
    logic [DATA_W-1:0] free_count;

    pool_result_t pending_results [$];
    int unsigned  held_idx [$];
    pool_result_t want;

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_len = 0;
    int  hold_pulses = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    fixed_block_pool_allocator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .free_address    (free_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .block_address   (block_address),
        .live_blocks     (live_blocks),
        .peak_blocks     (peak_blocks),
        .total_allocated (total_allocated),
        .total_freed     (total_freed)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] block_addr(int unsigned idx);
        return pool_base + DATA_W'(idx) * DATA_W'(pool_size);
    endfunction

    function automatic pool_result_t predict_request(logic kind, logic [DATA_W-1:0] addr);
        pool_result_t r;
        logic [63:0]  start;
        logic [63:0]  stop;
        logic [63:0]  offset;
        bit           bad;
        int unsigned  idx;
        r.status = ST_OK;
        r.addr = '0;
        if (kind == REQ_ALLOC) begin
            if (free_depth == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                free_depth--;
                idx = free_stack[free_depth];
                r.addr = block_addr(idx);
                alloc_count++;
                live_count++;
                if (live_count > peak_count)
                    peak_count = live_count;
                held_idx.push_back(idx);
            end
        end
        else if (addr == '0) begin
            r.status = ST_NULL;
        end
        else begin
            start = 64'(pool_base);
            stop = start + 64'(pool_size) * 64'(NBLK);
            offset = 64'(addr) - start;
            bad = 1'b1;
            if (pool_size != 0 && 64'(addr) >= start && 64'(addr) < stop)
                bad = (offset % 64'(pool_size)) != 0;
            if (bad) begin
                r.status = ST_BAD;
            end
            else if (free_depth >= NBLK) begin
                r.status = ST_FULL;
            end
            else begin
                free_stack[free_depth] = IDX_W'(offset / 64'(pool_size));
                free_depth++;
                if (live_count > 0)
                    live_count--;
                free_count++;
            end
        end
        r.live = COUNT_OUT_W'(live_count);
        r.peak = COUNT_OUT_W'(peak_count);
        r.allocs = alloc_count;
        r.frees = free_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want_v, logic [DATA_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s expected %0h got %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Check results before accepting the next request; both can fall in the same cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending, status %0d", status);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("block_address", want.addr, block_address);
                    check_field("live_blocks", want.live, live_blocks);
                    check_field("peak_blocks", want.peak, peak_blocks);
                    check_field("total_allocated", want.allocs, total_allocated);
                    check_field("total_freed", want.frees, total_freed);
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(predict_request(req_type, free_address));
            if (cfg_we) begin
                if (cfg_index == REG_BASE)
                    pool_base = cfg_data;
                else
                    pool_size = cfg_data[SIZE_W-1:0];
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("fixed_block_pool_allocator_unit_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off when a test requests one.
    always @(negedge clk) begin
        logic stall_now;
        if (hold_served != hold_pulses) begin
            hold_served = hold_pulses;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
        end
        else begin
            if (stall_left == 0 && rx_idle_on)
                stall_left = pick_gap();
            stall_now = stall_left > 0;
            if (stall_left > 0)
                stall_left--;
        end
        out_stall <= stall_now;
    end

    task automatic send_request(logic kind, logic [DATA_W-1:0] addr);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= kind;
        free_address <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_pool(logic [DATA_W-1:0] base, logic [SIZE_W-1:0] size);
        write_reg(REG_BASE, base);
        // upper data bits are junk; the size register keeps only its low bits
        write_reg(REG_SIZE, {16'($urandom()), size});
    endtask

    task automatic send_mixed(int count);
        int                r;
        int                alloc_pct;
        int unsigned       pick;
        logic              kind;
        logic [DATA_W-1:0] addr;
        repeat (count) begin
            r = $urandom_range(0, 99);
            alloc_pct = free_depth < 32 ? 25 : (free_depth > NBLK - 32 ? 60 : 42);
            kind = REQ_FREE;
            addr = $urandom();
            if (r < alloc_pct) begin
                kind = REQ_ALLOC;
            end
            else if (r < alloc_pct + 38 && held_idx.size() > 0) begin
                pick = $urandom_range(0, held_idx.size() - 1);
                addr = block_addr(held_idx[pick]);
                held_idx.delete(pick);
            end
            else begin
                case ($urandom_range(0, 9))
                    0: addr = '0;
                    1, 2: addr = block_addr($urandom_range(0, NBLK - 1));
                    3: addr = pool_base - 1;
                    4: addr = block_addr(NBLK);
                    5: addr = block_addr($urandom_range(0, NBLK - 1)) + $urandom_range(1, 7);
                    6: addr = block_addr(NBLK - 1);
                    default: ;
                endcase
            end
            send_request(kind, addr);
        end
    endtask

    task automatic test_directed();
        send_request(REQ_FREE, '0);
        send_request(REQ_FREE, 32'd4096);
        send_request(REQ_FREE, 32'd4095);
        send_request(REQ_FREE, 32'd4096 + 16 * NBLK);
        send_request(REQ_FREE, 32'd4096 + 16 * (NBLK - 1));
        send_request(REQ_FREE, 32'd4097);
        send_request(REQ_FREE, '1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '1);
        send_request(REQ_ALLOC, 32'h5A5A_A5A5);
        // same block four times: one genuine free, two double frees, the last finds it full
        repeat (4) send_request(REQ_FREE, 32'd4096 + 16 * (NBLK - 2));
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        wait_idle();
    endtask

    task automatic test_special_configs();
        set_pool(32'd4096, 16'd0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 32'd4096);
        send_request(REQ_FREE, 32'd1);
        send_request(REQ_FREE, '0);
        // top of the address space: every block past the first wraps
        set_pool('1, '1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 32'h0000_FFFE);
        send_request(REQ_FREE, '1);
        set_pool(32'd1, 16'd1);
        send_request(REQ_ALLOC, '0);
        send_request(REQ_FREE, 32'd1);
        send_request(REQ_FREE, 32'd1 + NBLK);
        send_request(REQ_FREE, 32'd1 + NBLK - 1);
        wait_idle();
    endtask

    task automatic test_pool_exhaustion();
        int          n;
        int unsigned pick;
        set_pool(32'h0010_0000, 16'd64);
        n = free_depth + 3;
        repeat (n) send_request(REQ_ALLOC, $urandom());
        while (held_idx.size() > 0) begin
            pick = $urandom_range(0, held_idx.size() - 1);
            send_request(REQ_FREE, block_addr(held_idx[pick]));
            held_idx.delete(pick);
        end
        wait_idle();
    endtask

    task automatic test_config_sweep();
        logic [DATA_W-1:0] bases [7];
        logic [SIZE_W-1:0] sizes [7];
        bases = '{32'd4096, 32'h8000_0000, 32'hFFFF_FF00, 32'd1, 32'hFFFF_0000,
                  32'd12345, 32'd0};
        sizes = '{16'd16, 16'd3, 16'd7, 16'd1, 16'd255, 16'hFFFF, 16'd0};
        bases[6] = $urandom_range(1, 32'hFFFF_FFFF);
        sizes[6] = $urandom_range(1, 64);
        for (int i = 0; i < 7; i++) begin
            set_pool(bases[i], sizes[i]);
            tx_idle_on = i != 2;
            rx_idle_on = i != 3;
            send_mixed(110);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_pool(32'h0000_2000, 16'd32);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_len = 400;
        hold_pulses++;
        send_mixed(40);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_sender_pause();
        send_mixed(30);
        // hold the sender until every result is back
        wait_idle();
        send_mixed(30);
        wait_idle();
    endtask

    initial begin
        pool_base = BASE_RESET;
        pool_size = SIZE_RESET;
        for (int i = 0; i < NBLK; i++)
            free_stack[i] = IDX_W'(i);
        free_depth = NBLK;
        live_count = 0;
        peak_count = 0;
        alloc_count = '0;
        free_count = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_special_configs();
        test_pool_exhaustion();
        test_config_sweep();
        test_backpressure();
        test_sender_pause();
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("fixed_block_pool_allocator_unit_tb OK");
        else
            $display("fixed_block_pool_allocator_unit_tb NOT OK");
        $finish;
    end

endmodule
